// File: rtl/utf8wa_pkg.sv
// Package for the UTF-8 to WinAnsi encoder.
// Holds the UTF-8 lead byte codes, the WinAnsi quote codes and the mapping function.
// No dependencies.
package utf8wa_pkg;

  localparam int unsigned CpWidth = 21;

  typedef logic [CpWidth-1:0] cp_t;
  typedef logic [1:0]         pend_t;

  // Lead byte patterns and their masks.
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam pend_t PendNone = 2'd0;
  localparam pend_t PendOne  = 2'd1;
  localparam pend_t PendTwo  = 2'd2;
  localparam pend_t PendThr  = 2'd3;

  localparam cp_t CpLsquo    = 21'h002018;
  localparam cp_t CpRsquo    = 21'h002019;
  localparam cp_t CpLdquo    = 21'h00201C;
  localparam cp_t CpRdquo    = 21'h00201D;
  localparam cp_t CpFirstPr  = 21'h000020;
  localparam cp_t CpLastPr   = 21'h0000FF;

  localparam logic [7:0] WaLsquo    = 8'h91;
  localparam logic [7:0] WaRsquo    = 8'h92;
  localparam logic [7:0] WaLdquo    = 8'h93;
  localparam logic [7:0] WaRdquo    = 8'h94;
  localparam logic [7:0] WaQuestion = 8'h3F;

  function automatic logic [7:0] winansi_of(input cp_t cp);
    logic [7:0] res;
    if (cp >= CpFirstPr && cp <= CpLastPr) begin
      res = cp[7:0];
    end else if (cp == CpLsquo) begin
      res = WaLsquo;
    end else if (cp == CpRsquo) begin
      res = WaRsquo;
    end else if (cp == CpLdquo) begin
      res = WaLdquo;
    end else if (cp == CpRdquo) begin
      res = WaRdquo;
    end else begin
      res = WaQuestion;
    end
    return res;
  endfunction

endpackage

// File: rtl/utf8_to_winansi_encoder_unit.sv
// Each byte is decoded from the stage-one register into the output register.
// Throughput: one byte per cycle unless the output stalls; the decoder state
// (accumulator and pending count) is updated once per byte in a single
// registered decode stage. Bytes that complete no character and are not last
// give no output word. Reset (rst_n low, synchronous) empties both stages and
// clears the decoder.
module utf8_to_winansi_encoder_unit
  import utf8wa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_in
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] has_byte
  output logic       out_tlast   // is_last
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  cp_t        acc_r, acc_nxt, acc_shift, cp;
  pend_t      pend_r, pend_nxt;
  logic       done;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_has_r;
  logic       out_last_r;

  logic       s1_fire;
  logic       emit;
  logic       in_fire;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    done      = 1'b0;
    cp        = '0;
    acc_shift = {acc_r[CpWidth-7:0], s1_byte_r[5:0]};
    if (pend_r != PendNone) begin
      acc_nxt  = acc_shift;
      pend_nxt = pend_r - PendOne;
      if (pend_r == PendOne) begin
        cp   = acc_shift;
        done = 1'b1;
      end
    end else if (!s1_byte_r[7]) begin
      cp   = {{(CpWidth-8){1'b0}}, s1_byte_r};
      done = 1'b1;
    end else if ((s1_byte_r & Lead2Mask) == Lead2Code) begin
      acc_nxt  = {{(CpWidth-5){1'b0}}, s1_byte_r[4:0]};
      pend_nxt = PendOne;
    end else if ((s1_byte_r & Lead3Mask) == Lead3Code) begin
      acc_nxt  = {{(CpWidth-4){1'b0}}, s1_byte_r[3:0]};
      pend_nxt = PendTwo;
    end else if ((s1_byte_r & Lead4Mask) == Lead4Code) begin
      acc_nxt  = {{(CpWidth-3){1'b0}}, s1_byte_r[2:0]};
      pend_nxt = PendThr;
    end
    // Stray continuation bytes and bytes 0xF8 to 0xFF fall through and leave the state alone.
    if (done) begin
      acc_nxt = '0;
    end
    if (s1_last_r) begin
      acc_nxt  = '0;
      pend_nxt = PendNone;
    end
  end

  assign emit = done || s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      pend_r      <= PendNone;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
      end
      if (s1_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_fire && emit) begin
      out_data_r <= done ? winansi_of(cp) : 8'h00;
      out_has_r  <= done;
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // The end of a string always returns the decoder to its idle state.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> (pend_r == PendNone) && (acc_r == '0))
    else $error("decoder state not cleared after last byte");

  // A completed character clears the accumulator.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && done |=> acc_r == '0)
    else $error("accumulator not cleared after a character");

  // A word without a character exists only to mark the end of a string.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_has_r |-> out_last_r && (out_data_r == 8'h00))
    else $error("empty output word without last flag or with data");

  // The pending count is zero whenever a character completes.
  a_done_pend: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && done |-> pend_nxt == PendNone)
    else $error("character completed with bytes still pending");
`endif

endmodule

// File: test/winansi_decode_checker.sv
// Checker for the UTF-8 to WinAnsi encoder: watches both word channels, decodes
// the accepted input bytes on its own and compares every output word in order.
// Depends on utf8wa_pkg for the code point type and the character constants.
module winansi_decode_checker
  import utf8wa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tuser,
  input  logic       out_tlast,
  output int         errors,
  output int         chars_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_ch;
    logic       ends_text;
  } char_word_t;

  char_word_t owed_chars[$];
  cp_t        code_sum;
  pend_t      cont_left;

  initial begin
    errors     = 0;
    chars_owed = 0;
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [7:0] map_winansi(input cp_t cp);
    logic [7:0] ch;
    case (cp)
      CpLsquo: ch = WaLsquo;
      CpRsquo: ch = WaRsquo;
      CpLdquo: ch = WaLdquo;
      CpRdquo: ch = WaRdquo;
      default: ch = (cp >= CpFirstPr && cp <= CpLastPr) ? cp[7:0] : WaQuestion;
    endcase
    return ch;
  endfunction

  // Continuation bytes are taken on trust: only their low six bits are kept.
  task automatic decode_byte(input logic [7:0] b, input logic ends_text);
    logic done;
    cp_t  cp;
    done = 1'b0;
    cp   = '0;
    if (cont_left != PendNone) begin
      code_sum  = {code_sum[CpWidth-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == PendNone) begin
        cp   = code_sum;
        done = 1'b1;
      end
    end else if (!b[7]) begin
      cp   = cp_t'(b);
      done = 1'b1;
    end else if ((b & Lead2Mask) == Lead2Code) begin
      code_sum  = cp_t'(b[4:0]);
      cont_left = PendOne;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      code_sum  = cp_t'(b[3:0]);
      cont_left = PendTwo;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      code_sum  = cp_t'(b[2:0]);
      cont_left = PendThr;
    end
    if (done || ends_text) code_sum = '0;
    if (ends_text) cont_left = PendNone;
    if (done) begin
      owed_chars.push_back('{ch: map_winansi(cp), has_ch: 1'b1, ends_text: ends_text});
    end else if (ends_text) begin
      owed_chars.push_back('{ch: 8'h00, has_ch: 1'b0, ends_text: 1'b1});
    end
  endtask

  always @(posedge clk) begin
    char_word_t want;
    if (!rst_n) begin
      code_sum  = '0;
      cont_left = PendNone;
      owed_chars.delete();
    end else begin
      // Outputs first: a word leaving at this edge was predicted at an earlier one.
      if (out_tvalid && out_tready) begin
        if (owed_chars.size() == 0) begin
          report("output word with no character owed", out_tdata, 8'h00);
        end else begin
          want = owed_chars.pop_front();
          if (out_tdata !== want.ch) report("out_byte", out_tdata, want.ch);
          if (out_tuser !== want.has_ch) report("has_byte", 8'(out_tuser), 8'(want.has_ch));
          if (out_tlast !== want.ends_text) report("is_last", 8'(out_tlast), 8'(want.ends_text));
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    chars_owed <= owed_chars.size();
  end

endmodule

// File: test/utf8_to_winansi_encoder_unit_tb.sv
// Testbench top for utf8_to_winansi_encoder_unit: drives UTF-8 text byte by byte
// with random gaps and back-pressure, and gives the verdict.
// Depends on the encoder RTL, utf8wa_pkg and winansi_decode_checker.
module utf8_to_winansi_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TextBytes = 1600;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  int errors;
  int chars_owed;
  int send_idle_pct = 8;
  int recv_idle_pct = 82;
  int bytes_sent    = 0;

  utf8_to_winansi_encoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  winansi_decode_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .errors    (errors),
    .chars_owed(chars_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(input logic [7:0] b, input logic ends_text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= ends_text;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Mostly a proper continuation byte, now and then one with wrong top bits.
  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(7) == 0) ? 2'($urandom_range(3)) : 2'b10;
    return {top, bits};
  endfunction

  task automatic send_string();
    logic [7:0]  txt[$];
    logic [20:0] cp;
    int unsigned n_chars;
    n_chars = $urandom_range(1, 10);
    repeat (n_chars) begin
      case ($urandom_range(9))
        0, 1, 2: txt.push_back(8'($urandom_range(127)));
        3, 4: begin
          cp = 21'($urandom_range(21'h7FF));
          txt.push_back({3'b110, cp[10:6]});
          txt.push_back(cont_byte(cp[5:0]));
        end
        5, 6: begin
          // Half of the three-byte characters land on or near the curly quotes.
          cp = ($urandom_range(1) == 0) ? 21'(21'h2018 + $urandom_range(7))
                                        : 21'($urandom_range(16'hFFFF));
          txt.push_back({4'b1110, cp[15:12]});
          txt.push_back(cont_byte(cp[11:6]));
          txt.push_back(cont_byte(cp[5:0]));
        end
        7: begin
          cp = 21'($urandom_range(21'h1FFFFF));
          txt.push_back({5'b11110, cp[20:18]});
          txt.push_back(cont_byte(cp[17:12]));
          txt.push_back(cont_byte(cp[11:6]));
          txt.push_back(cont_byte(cp[5:0]));
        end
        8: txt.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
        default: txt.push_back(8'($urandom_range(255)));
      endcase
    end
    // Some strings end in a bare lead byte or lose their final byte.
    if ($urandom_range(7) == 0) begin
      txt.push_back(8'($urandom_range(8'hC0, 8'hF7)));
    end else if ($urandom_range(7) == 0 && txt.size() > 1) begin
      void'(txt.pop_back());
    end
    foreach (txt[i]) send_word(txt[i], i == txt.size() - 1);
  endtask

  initial begin
    // Each entry is {last, byte}.
    logic [8:0] opening[$] = '{
      9'h000, 9'h07F, 9'h0C3, 9'h0BF, 9'h0C0, 9'h09F,
      9'h0E2, 9'h080, 9'h098, 9'h0E2, 9'h080, 9'h099,
      9'h0E2, 9'h080, 9'h09C, 9'h0E2, 9'h080, 9'h09D,
      9'h0F4, 9'h08F, 9'h0BF, 9'h0BF, 9'h080, 9'h0FF,
      9'h0C3, 9'h041, 9'h0E2, 9'h180, 9'h1C3
    };
    int send_pcts[3] = '{8, 82, 0};
    int recv_pcts[3] = '{82, 8, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_idle_pct = recv_pcts[phase];
      if (phase == 0) begin
        foreach (opening[i]) send_word(opening[i][7:0], opening[i][8]);
      end
      while (bytes_sent < TextBytes * (phase + 1) / 3) send_string();
      if (phase == 0) begin
        // Hold the input off until the encoder has drained completely.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (chars_owed != 0);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (chars_owed != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("utf8_to_winansi_encoder_unit_tb: done, clean");
    end else begin
      $display("utf8_to_winansi_encoder_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("utf8_to_winansi_encoder_unit_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/utf8wa_pkg.sv
rtl/utf8_to_winansi_encoder_unit.sv
test/winansi_decode_checker.sv
test/utf8_to_winansi_encoder_unit_tb.sv
